/* design/swal_pkg.sv */
package swal_pkg;

    localparam int NUM_KINDS   = 8;
    localparam int MAX_RECORDS = 64;
    localparam int TIME_W      = 32;
    localparam int KEY_W       = 32;
    localparam int REQ_W       = 3;
    localparam int KINDF_W     = 3;
    localparam int COUNT_W     = 7;

    localparam int KIND_W  = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int IDX_W   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W   = $clog2(MAX_RECORDS + 1);
    localparam int ADDR_W  = KIND_W + IDX_W;
    localparam int DEPTH   = NUM_KINDS * (1 << IDX_W);
    localparam int DUP_W   = KEY_W + TIME_W;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_RECORD,
        REQ_PRUNE,
        REQ_COUNT,
        REQ_EARLY,
        REQ_LOOKUP
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_ACT,
        PH_DUP,
        PH_SHIFT
    } t_phase;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
    } t_mem_ctl;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  tval;
        logic [TIME_W-1:0]  last_time;
        logic               last_valid;
    } t_result;

    // t < now - span, cutoff before zero never reached
    function automatic logic older(input logic [TIME_W-1:0] t,
                                   input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] span);
        older = (now >= span) && (t < (now - span));
    endfunction

endpackage

/* design/swal_ram.sv */
module swal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/swal_seq.sv */
module swal_seq
    import swal_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [KINDF_W-1:0]  i_kind,
    input  logic [TIME_W-1:0]   i_now,
    input  logic [KEY_W-1:0]    i_dedup_key,
    input  logic [TIME_W-1:0]   i_window_seconds,
    input  logic [TIME_W-1:0]   i_min_interval_seconds,
    input  logic [TIME_W-1:0]   i_cooldown_seconds,
    output logic                o_busy,
    output t_mem_ctl            o_act_ctl,
    output logic [TIME_W-1:0]   o_act_wdata,
    input  logic [TIME_W-1:0]   i_act_rdata,
    output t_mem_ctl            o_dup_ctl,
    output logic [DUP_W-1:0]    o_dup_wdata,
    input  logic [DUP_W-1:0]    i_dup_rdata,
    output logic                o_res_valid,
    output t_result             o_res,
    input  logic                i_res_ready
);

    t_state r_state, n_state;
    t_phase r_phase;

    logic [REQ_W-1:0]   r_req;
    logic [KINDF_W-1:0] r_kind;
    logic [TIME_W-1:0]  r_now;
    logic [KEY_W-1:0]   r_key;
    logic [TIME_W-1:0]  r_win, r_mint, r_cool, r_span;
    logic               r_kok, r_modify;
    logic [CNT_W-1:0]   r_rd, r_end, r_wr;
    logic               r_pv;
    logic               r_found;
    logic [COUNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]  r_tval;

    logic [CNT_W-1:0]   r_act_fill [NUM_KINDS];
    logic [CNT_W-1:0]   r_dup_fill [NUM_KINDS];
    logic [TIME_W-1:0]  r_last     [NUM_KINDS];
    logic               r_last_set [NUM_KINDS];

    logic [KIND_W-1:0]  kidx;
    logic               kind_ok, req_ok, is_rec;
    logic [TIME_W-1:0]  horizon, clamped;
    logic               scan_end, act_keep, dup_keep, dup_hit;
    logic [KEY_W-1:0]   dup_k;
    logic [TIME_W-1:0]  dup_t;
    logic               dup_full;

    assign kidx     = KIND_W'(r_kind);
    assign kind_ok  = (32'(r_kind) < NUM_KINDS);
    assign req_ok   = (r_req inside {REQ_RECORD, REQ_PRUNE, REQ_COUNT, REQ_EARLY, REQ_LOOKUP});
    assign is_rec   = (r_req == REQ_RECORD);
    assign horizon  = (r_win > r_mint) ? ((r_win > TIME_W'(1)) ? r_win : TIME_W'(1))
                                       : ((r_mint > TIME_W'(1)) ? r_mint : TIME_W'(1));
    assign clamped  = (r_last_set[kidx] && (r_now < r_last[kidx])) ? r_last[kidx] : r_now;
    assign scan_end = (r_rd >= r_end) && !r_pv;
    assign dup_k    = i_dup_rdata[DUP_W-1 -: KEY_W];
    assign dup_t    = i_dup_rdata[TIME_W-1:0];
    assign act_keep = !older(i_act_rdata, r_now, r_span);
    assign dup_hit  = (dup_k == r_key);
    assign dup_keep = (r_phase == PH_SHIFT) ||
                      (!older(dup_t, r_now, r_cool) && !(is_rec && dup_hit));
    assign dup_full = (r_wr == CNT_W'(MAX_RECORDS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = (kind_ok && req_ok) ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                if (scan_end) begin
                    case (r_phase)
                        PH_ACT: begin
                            if (!r_modify || r_cool == '0) n_state = ST_DONE;
                        end
                        PH_DUP: begin
                            if (!(r_modify && is_rec && dup_full)) n_state = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_DONE: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy            = (r_state != ST_IDLE);
        o_act_ctl.raddr   = {kidx, r_rd[IDX_W-1:0]};
        o_act_ctl.waddr   = {kidx, r_wr[IDX_W-1:0]};
        o_act_ctl.we      = 1'b0;
        o_act_wdata       = i_act_rdata;
        o_dup_ctl.raddr   = {kidx, r_rd[IDX_W-1:0]};
        o_dup_ctl.waddr   = {kidx, r_wr[IDX_W-1:0]};
        o_dup_ctl.we      = 1'b0;
        o_dup_wdata       = i_dup_rdata;
        if (r_state == ST_SCAN && r_modify) begin
            if (r_phase == PH_ACT) begin
                if (r_pv && act_keep) o_act_ctl.we = 1'b1;
                if (scan_end && is_rec) begin
                    o_act_ctl.we = 1'b1;
                    o_act_wdata  = r_now;
                end
            end else begin
                if (r_pv && dup_keep) o_dup_ctl.we = 1'b1;
                if (scan_end && is_rec && (r_phase == PH_SHIFT || !dup_full)) begin
                    o_dup_ctl.we = 1'b1;
                    o_dup_wdata  = {r_key, r_now};
                end
            end
        end
        o_res_valid      = (r_state == ST_DONE);
        o_res.found      = r_found;
        o_res.count      = r_cnt;
        o_res.tval       = r_tval;
        o_res.last_time  = (r_kok && r_last_set[kidx]) ? r_last[kidx] : '0;
        o_res.last_valid = r_kok && r_last_set[kidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pv    <= 1'b0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_act_fill[k] <= '0;
                r_dup_fill[k] <= '0;
                r_last[k]     <= '0;
                r_last_set[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_req     <= i_req_type;
                        r_kind    <= i_kind;
                        r_now     <= i_now;
                        r_key     <= i_dedup_key;
                        r_win     <= i_window_seconds;
                        r_mint    <= i_min_interval_seconds;
                        r_cool    <= i_cooldown_seconds;
                    end
                end
                ST_SETUP: begin
                    r_kok    <= kind_ok;
                    r_modify <= (r_req == REQ_RECORD) || (r_req == REQ_PRUNE);
                    r_span   <= ((r_req == REQ_RECORD) || (r_req == REQ_PRUNE)) ? horizon : r_win;
                    r_found  <= kind_ok && is_rec;
                    r_cnt    <= '0;
                    r_tval   <= (kind_ok && is_rec) ? clamped : '0;
                    r_pv     <= 1'b0;
                    r_wr     <= '0;
                    r_phase  <= (r_req == REQ_LOOKUP) ? PH_DUP : PH_ACT;
                    r_end    <= (r_req == REQ_LOOKUP) ? r_dup_fill[kidx] : r_act_fill[kidx];
                    r_rd     <= (is_rec && r_act_fill[kidx] == CNT_W'(MAX_RECORDS))
                                ? CNT_W'(1) : '0;
                    if (kind_ok && is_rec) begin
                        r_now            <= clamped;
                        r_last[kidx]     <= clamped;
                        r_last_set[kidx] <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (r_rd < r_end) r_rd <= r_rd + CNT_W'(1);
                    r_pv <= (r_rd < r_end);
                    if (r_pv) begin
                        case (r_phase)
                            PH_ACT: begin
                                if (r_modify && act_keep) r_wr <= r_wr + CNT_W'(1);
                                if (r_req == REQ_COUNT && act_keep &&
                                    r_cnt != COUNT_W'(COUNT_MAX))
                                    r_cnt <= r_cnt + COUNT_W'(1);
                                if (r_req == REQ_EARLY && act_keep && !r_found) begin
                                    r_found <= 1'b1;
                                    r_tval  <= i_act_rdata;
                                end
                            end
                            PH_DUP: begin
                                if (r_modify && dup_keep) r_wr <= r_wr + CNT_W'(1);
                                if (r_req == REQ_LOOKUP && dup_hit && !r_found) begin
                                    r_found <= 1'b1;
                                    r_tval  <= dup_t;
                                end
                            end
                            default: r_wr <= r_wr + CNT_W'(1);
                        endcase
                    end
                    if (scan_end && r_modify) begin
                        case (r_phase)
                            PH_ACT: begin
                                r_act_fill[kidx] <= is_rec ? r_wr + CNT_W'(1) : r_wr;
                                if (r_cool == '0) begin
                                    r_dup_fill[kidx] <= '0;
                                end else begin
                                    r_phase <= PH_DUP;
                                    r_rd    <= '0;
                                    r_end   <= r_dup_fill[kidx];
                                    r_wr    <= '0;
                                end
                            end
                            PH_DUP: begin
                                if (is_rec && dup_full) begin
                                    r_phase <= PH_SHIFT;
                                    r_rd    <= CNT_W'(1);
                                    r_end   <= CNT_W'(MAX_RECORDS);
                                    r_wr    <= '0;
                                end else begin
                                    r_dup_fill[kidx] <= is_rec ? r_wr + CNT_W'(1) : r_wr;
                                end
                            end
                            default: r_dup_fill[kidx] <= r_wr + CNT_W'(1);
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* design/sliding_window_action_log.sv */
// Per-kind sliding-window action log with duplicate-key table. One request at a
// time: o_stall is high from acceptance until the result word is handed to the
// output register. With A the kind's log fill and D its duplicate-table fill, a
// count or earliest request scans the A log entries, a lookup the D table entries,
// and a prune or record scans both (only the log when the cooldown is zero); a
// record into a full duplicate table with no matching or expired key adds a shift
// pass that drops the oldest table entry. A stalled output holds the result until
// it is taken. Each pass reads one entry a cycle through the single read port of
// each memory. No clearing pass after reset.
module sliding_window_action_log
    import swal_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [KINDF_W-1:0]  i_kind,
    input  logic [TIME_W-1:0]   i_now,
    input  logic [KEY_W-1:0]    i_dedup_key,
    input  logic [TIME_W-1:0]   i_window_seconds,
    input  logic [TIME_W-1:0]   i_min_interval_seconds,
    input  logic [TIME_W-1:0]   i_cooldown_seconds,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_found,
    output logic [COUNT_W-1:0]  o_action_count,
    output logic [TIME_W-1:0]   o_time_value,
    output logic [TIME_W-1:0]   o_last_time,
    output logic                o_last_valid
);

    t_mem_ctl            act_ctl, dup_ctl;
    logic [TIME_W-1:0]   act_wdata, act_rdata;
    logic [DUP_W-1:0]    dup_wdata, dup_rdata;
    logic                busy, res_valid, slot_free;
    t_result             res;
    logic                r_valid;
    t_result             r_res;

    assign slot_free = !r_valid || !i_stall;
    assign o_stall   = busy;

    swal_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (act_ctl.we),
        .i_waddr (act_ctl.waddr),
        .i_wdata (act_wdata),
        .i_raddr (act_ctl.raddr),
        .o_rdata (act_rdata)
    );

    swal_ram #(.WIDTH(DUP_W), .DEPTH(DEPTH)) u_dup_ram (
        .i_clk   (i_clk),
        .i_we    (dup_ctl.we),
        .i_waddr (dup_ctl.waddr),
        .i_wdata (dup_wdata),
        .i_raddr (dup_ctl.raddr),
        .o_rdata (dup_rdata)
    );

    swal_seq u_seq (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_start                (i_valid && !busy),
        .i_req_type             (i_req_type),
        .i_kind                 (i_kind),
        .i_now                  (i_now),
        .i_dedup_key            (i_dedup_key),
        .i_window_seconds       (i_window_seconds),
        .i_min_interval_seconds (i_min_interval_seconds),
        .i_cooldown_seconds     (i_cooldown_seconds),
        .o_busy                 (busy),
        .o_act_ctl              (act_ctl),
        .o_act_wdata            (act_wdata),
        .i_act_rdata            (act_rdata),
        .o_dup_ctl              (dup_ctl),
        .o_dup_wdata            (dup_wdata),
        .i_dup_rdata            (dup_rdata),
        .o_res_valid            (res_valid),
        .o_res                  (res),
        .i_res_ready            (slot_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_res   <= '0;
        end else if (slot_free) begin
            r_valid <= res_valid;
            if (res_valid) r_res <= res;
        end
    end

    assign o_valid        = r_valid;
    assign o_found        = r_res.found;
    assign o_action_count = r_res.count;
    assign o_time_value   = r_res.tval;
    assign o_last_time    = r_res.last_time;
    assign o_last_valid   = r_res.last_valid;

endmodule

/* design/swal_chk.sv */
module swal_chk
    import swal_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic                o_found,
    input logic [COUNT_W-1:0]  o_action_count,
    input logic [TIME_W-1:0]   o_time_value,
    input logic [TIME_W-1:0]   o_last_time,
    input logic                o_last_valid
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("word dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input open right after accepting a word");

    a_nf_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_time_value == '0)
        else $error("time without found");

    a_cnt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action_count != '0 |-> !o_found)
        else $error("count and found together");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_valid |-> o_last_time == '0)
        else $error("last time without last valid");

endmodule

bind sliding_window_action_log swal_chk u_swal_chk (.*);
